@@ src/integer_divider_signed_unsigned_macros.svh @@
// assertion shorthands for the divider checker
`ifndef INTEGER_DIVIDER_SIGNED_UNSIGNED_MACROS_SVH
`define INTEGER_DIVIDER_SIGNED_UNSIGNED_MACROS_SVH

// same-cycle implication, checked out of reset
`define IDIV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define IDIV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/idiv_pkg.sv @@
package idiv_pkg;

	// width of the operand and result ports
	localparam int DATA_W = 32;

	// operation codes
	localparam logic [1:0] ACT_SQUO = 2'd0;
	localparam logic [1:0] ACT_SREM = 2'd1;
	localparam logic [1:0] ACT_UQUO = 2'd2;
	localparam logic [1:0] ACT_UREM = 2'd3;

	// control that travels with each transaction down the chain
	typedef struct packed {
		logic valid;
		logic neg_q;
		logic neg_r;
		logic zero;
		logic sel_rem;
	} ctl_t;

endpackage

@@ src/integer_divider_signed_unsigned.sv @@
// stages from request to response:
// one operand stage, WIDTH restoring-step cells, one output register
// throughput: one transaction per cycle while the skid slot is free; each cell does one quotient bit
// the output skid slot lets a new request in while a response waits
// reset clears the valid bits of every stage and both output slots
module integer_divider_signed_unsigned #(
	parameter int WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [1:0]                  action,
	input  logic [idiv_pkg::DATA_W-1:0] dividend,
	input  logic [idiv_pkg::DATA_W-1:0] divisor,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [idiv_pkg::DATA_W-1:0] result,
	output logic                        div_by_zero
);
	import idiv_pkg::*;

	logic             en;
	ctl_t             ctl_c [WIDTH+1];
	logic [WIDTH-1:0] rem_c [WIDTH+1];
	logic [WIDTH-1:0] quo_c [WIDTH+1];
	logic [WIDTH-1:0] den_c [WIDTH+1];

	assign req_ready = en;
	assign rem_c[0]  = '0;

	// operand stage
	idiv_prep #(.WIDTH(WIDTH)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.req_valid (req_valid),
		.action    (action),
		.dividend  (dividend),
		.divisor   (divisor),
		.ctl_s1    (ctl_c[0]),
		.quo_s1    (quo_c[0]),
		.den_s1    (den_c[0])
	);

	// one cell per quotient bit
	generate
		for (genvar i = 0; i < WIDTH; i++) begin : g_cell
			idiv_cell #(.WIDTH(WIDTH)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.ctl_in (ctl_c[i]),
				.rem_in (rem_c[i]),
				.quo_in (quo_c[i]),
				.den_in (den_c[i]),
				.ctl_q  (ctl_c[i+1]),
				.rem_q  (rem_c[i+1]),
				.quo_q  (quo_c[i+1]),
				.den_q  (den_c[i+1])
			);
		end
	endgenerate

	// sign fix and output slots
	idiv_post #(.WIDTH(WIDTH)) u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_in      (ctl_c[WIDTH]),
		.rem_in      (rem_c[WIDTH]),
		.quo_in      (quo_c[WIDTH]),
		.en          (en),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.result      (result),
		.div_by_zero (div_by_zero)
	);

endmodule

@@ src/idiv_prep.sv @@
module idiv_prep #(
	parameter int WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      req_valid,
	input  logic [1:0]                action,
	input  logic [idiv_pkg::DATA_W-1:0] dividend,
	input  logic [idiv_pkg::DATA_W-1:0] divisor,
	output idiv_pkg::ctl_t            ctl_s1,
	output logic [WIDTH-1:0]          quo_s1,
	output logic [WIDTH-1:0]          den_s1
);
	import idiv_pkg::*;

	logic [WIDTH-1:0] a;
	logic [WIDTH-1:0] b;
	logic             is_signed;
	logic             a_neg;
	logic             b_neg;

	// take the operands modulo 2^WIDTH
	generate
		if (WIDTH <= DATA_W) begin : g_trunc
			assign a = dividend[WIDTH-1:0];
			assign b = divisor[WIDTH-1:0];
		end else begin : g_ext
			assign a = {{(WIDTH-DATA_W){1'b0}}, dividend};
			assign b = {{(WIDTH-DATA_W){1'b0}}, divisor};
		end
	endgenerate

	assign is_signed = (action == ACT_SQUO) || (action == ACT_SREM);
	assign a_neg     = is_signed & a[WIDTH-1];
	assign b_neg     = is_signed & b[WIDTH-1];

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid   <= req_valid;
			ctl_s1.neg_q   <= a_neg ^ b_neg;
			ctl_s1.neg_r   <= a_neg;
			ctl_s1.zero    <= (b == '0);
			ctl_s1.sel_rem <= (action == ACT_SREM) || (action == ACT_UREM);
		end
	end

	// operand magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			quo_s1 <= a_neg ? (~a + 1'b1) : a;
			den_s1 <= b_neg ? (~b + 1'b1) : b;
		end
	end

endmodule

@@ src/idiv_cell.sv @@
module idiv_cell #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  idiv_pkg::ctl_t   ctl_in,
	input  logic [WIDTH-1:0] rem_in,
	input  logic [WIDTH-1:0] quo_in,
	input  logic [WIDTH-1:0] den_in,
	output idiv_pkg::ctl_t   ctl_q,
	output logic [WIDTH-1:0] rem_q,
	output logic [WIDTH-1:0] quo_q,
	output logic [WIDTH-1:0] den_q
);
	import idiv_pkg::*;

	logic [WIDTH+1:0] diff;
	logic             fits;

	// trial subtract of the divisor from the shifted partial remainder
	assign diff = {1'b0, rem_in, quo_in[WIDTH-1]} - {2'b00, den_in};
	assign fits = ~diff[WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	// restore or keep, shift the quotient bit in from the bottom
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fits ? diff[WIDTH-1:0] : {rem_in[WIDTH-2:0], quo_in[WIDTH-1]};
			quo_q <= {quo_in[WIDTH-2:0], fits};
			den_q <= den_in;
		end
	end

endmodule

@@ src/idiv_post.sv @@
module idiv_post #(
	parameter int WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  idiv_pkg::ctl_t              ctl_in,
	input  logic [WIDTH-1:0]            rem_in,
	input  logic [WIDTH-1:0]            quo_in,
	output logic                        en,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [idiv_pkg::DATA_W-1:0] result,
	output logic                        div_by_zero
);
	import idiv_pkg::*;

	logic [WIDTH-1:0]  q_fix;
	logic [WIDTH-1:0]  r_fix;
	logic [WIDTH-1:0]  sel;
	logic [DATA_W-1:0] res_new;
	logic              take;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_res_q;
	logic              out_dbz_q;
	logic              skid_valid_q;
	logic [DATA_W-1:0] skid_res_q;
	logic              skid_dbz_q;

	// sign correction and selection
	assign q_fix = ctl_in.neg_q ? (~quo_in + 1'b1) : quo_in;
	assign r_fix = ctl_in.neg_r ? (~rem_in + 1'b1) : rem_in;
	assign sel   = ctl_in.zero ? '0 : (ctl_in.sel_rem ? r_fix : q_fix);

	generate
		if (WIDTH >= DATA_W) begin : g_trunc
			assign res_new = sel[DATA_W-1:0];
		end else begin : g_ext
			assign res_new = {{(DATA_W-WIDTH){1'b0}}, sel};
		end
	endgenerate

	// chain moves whenever the skid slot is free
	assign en   = ~skid_valid_q;
	assign take = ctl_in.valid & en;

	// output register with skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (out_valid_q && rsp_ready) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= take;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= take;
			end else begin
				if (take) begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (out_valid_q && rsp_ready) begin
			if (skid_valid_q) begin
				out_res_q <= skid_res_q;
				out_dbz_q <= skid_dbz_q;
			end else if (take) begin
				out_res_q <= res_new;
				out_dbz_q <= ctl_in.zero;
			end
		end else if (!out_valid_q) begin
			if (take) begin
				out_res_q <= res_new;
				out_dbz_q <= ctl_in.zero;
			end
		end else begin
			if (take) begin
				skid_res_q <= res_new;
				skid_dbz_q <= ctl_in.zero;
			end
		end
	end

	assign rsp_valid   = out_valid_q;
	assign result      = out_res_q;
	assign div_by_zero = out_dbz_q;

endmodule

@@ src/idiv_check.sv @@
`include "integer_divider_signed_unsigned_macros.svh"

module idiv_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic [1:0]                  action,
	input logic [idiv_pkg::DATA_W-1:0] dividend,
	input logic [idiv_pkg::DATA_W-1:0] divisor,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [idiv_pkg::DATA_W-1:0] result,
	input logic                        div_by_zero
);

	// a stalled request holds
	`IDIV_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable({action, dividend, divisor}), "stalled request changed")

	// a stalled response holds
	`IDIV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(result) && $stable(div_by_zero), "stalled response changed")

	// divide by zero always reports a zero result
	`IDIV_ASSERT_NOW(a_dbz_zero, rsp_valid && div_by_zero, result == '0, "nonzero result on divide by zero")

	// requests are only held off while a response is pending
	`IDIV_ASSERT_NOW(a_backpressure, !req_ready, rsp_valid, "request stalled with no pending response")

endmodule

bind integer_divider_signed_unsigned idiv_check u_idiv_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_ready   (req_ready),
	.action      (action),
	.dividend    (dividend),
	.divisor     (divisor),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.result      (result),
	.div_by_zero (div_by_zero)
);

@@ test/tb_integer_divider_signed_unsigned.sv @@
module tb_integer_divider_signed_unsigned;
	import idiv_pkg::*;

	// one request as queued for the driver
	typedef struct {
		logic [1:0]        action;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
		int                gap;
		bit                drain;
	} div_op_t;

	// predicted response with the request it came from
	typedef struct {
		logic [1:0]        action;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
		logic [DATA_W-1:0] result;
		logic              div_by_zero;
	} div_answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic [1:0]        action = ACT_SQUO;
	logic [DATA_W-1:0] dividend = '0;
	logic [DATA_W-1:0] divisor = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic [DATA_W-1:0] result;
	logic              div_by_zero;

	div_op_t     pending_divs[$];
	div_answer_t due_answers[$];
	int          errors = 0;
	int          answers_seen = 0;
	int          gap_left = 0;
	int          hold_left = 0;
	int          stall_left = 0;
	bit          hold_done = 1'b0;

	integer_divider_signed_unsigned #(.WIDTH(DATA_W)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.action      (action),
		.dividend    (dividend),
		.divisor     (divisor),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.result      (result),
		.div_by_zero (div_by_zero)
	);

	always #1 clk = ~clk;

	// truncating division; the remainder follows the sign of the dividend
	function automatic div_answer_t compute_quotient_remainder(logic [1:0] act,
			logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		div_answer_t       ans;
		logic              neg_a;
		logic              neg_b;
		logic [DATA_W-1:0] mag_a;
		logic [DATA_W-1:0] mag_b;
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] rem;
		ans.action = act;
		ans.dividend = a;
		ans.divisor = b;
		ans.result = '0;
		ans.div_by_zero = 1'b1;
		if (b == '0)
			return ans;
		ans.div_by_zero = 1'b0;
		if (act == ACT_SQUO || act == ACT_SREM) begin
			neg_a = a[DATA_W-1];
			neg_b = b[DATA_W-1];
			mag_a = neg_a ? -a : a;
			mag_b = neg_b ? -b : b;
			quo = mag_a / mag_b;
			rem = mag_a % mag_b;
			if (neg_a != neg_b)
				quo = -quo;
			if (neg_a)
				rem = -rem;
		end else begin
			quo = a / b;
			rem = a % b;
		end
		ans.result = (act == ACT_SREM || act == ACT_UREM) ? rem : quo;
		return ans;
	endfunction

	task automatic report_mismatch(string what, div_answer_t want, logic [DATA_W-1:0] got);
		$display("mismatch %s: action %0d dividend %h divisor %h got %h want %h", what,
			want.action, want.dividend, want.divisor, got,
			(what == "div_by_zero") ? DATA_W'(want.div_by_zero) : want.result);
		errors++;
	endtask

	task automatic queue_div(logic [1:0] act, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
			int gap, bit drain);
		div_op_t op;
		op.action = act;
		op.dividend = a;
		op.divisor = b;
		op.gap = gap;
		op.drain = drain;
		pending_divs.push_back(op);
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// operand shapes that reach small, negative and boundary values
	function automatic logic [DATA_W-1:0] pick_operand();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 6))
			0: v = $urandom();
			1: v = $urandom_range(0, 15);
			2: begin
				v = $urandom_range(1, 15);
				v = -v;
			end
			3: v = {1'b1, 31'($urandom())};
			4: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'hffff_ffff;
					default: v = 32'h0000_0001;
				endcase
			end
			5: v = $urandom() >> $urandom_range(0, 31);
			default: v = $urandom();
		endcase
		return v;
	endfunction

	// request driver: presents queued transactions, holds them until accepted
	always @(posedge clk) begin : req_driver
		div_op_t nxt;
		logic    fire;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			fire = req_valid && req_ready;
			if (fire)
				due_answers.push_back(compute_quotient_remainder(action, dividend, divisor));
			if (!req_valid || fire) begin
				if (pending_divs.size() == 0) begin
					req_valid <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_divs[0].drain && due_answers.size() != 0) begin
					req_valid <= 1'b0;
				end else begin
					nxt = pending_divs.pop_front();
					req_valid <= 1'b1;
					action <= nxt.action;
					dividend <= nxt.dividend;
					divisor <= nxt.divisor;
					if (pending_divs.size() != 0)
						gap_left <= pending_divs[0].gap;
				end
			end
		end
	end

	// response pacing: random stalls, one long hold-off, one calm window
	always @(posedge clk) begin : rsp_pacing
		int roll;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (!hold_done && answers_seen >= 150) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (answers_seen >= 300 && answers_seen < 360) begin
			rsp_ready <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b0;
				stall_left <= (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
			end
		end
	end

	// response monitor: each transaction against the oldest prediction
	always @(posedge clk) begin : rsp_monitor
		div_answer_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (due_answers.size() == 0) begin
				$display("unexpected response: result %h div_by_zero %b", result, div_by_zero);
				errors++;
			end else begin
				want = due_answers.pop_front();
				if (result !== want.result)
					report_mismatch("result", want, result);
				if (div_by_zero !== want.div_by_zero)
					report_mismatch("div_by_zero", want, DATA_W'(div_by_zero));
			end
			answers_seen <= answers_seen + 1;
		end
	end

	// stimulus and end of run
	initial begin
		logic [1:0]        act;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		int                roll;

		// divide by zero on every operation
		queue_div(ACT_SQUO, 32'h0000_0064, 32'h0000_0000, 0, 1'b0);
		queue_div(ACT_SREM, 32'h8000_0000, 32'h0000_0000, 0, 1'b0);
		queue_div(ACT_UQUO, 32'hffff_ffff, 32'h0000_0000, 1, 1'b0);
		queue_div(ACT_UREM, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
		// most negative over minus one wraps
		queue_div(ACT_SQUO, 32'h8000_0000, 32'hffff_ffff, 0, 1'b0);
		queue_div(ACT_SREM, 32'h8000_0000, 32'hffff_ffff, 0, 1'b0);
		// both operands negative
		queue_div(ACT_SQUO, 32'hffff_fff9, 32'hffff_fffe, 2, 1'b0);
		queue_div(ACT_SREM, 32'hffff_fff9, 32'hffff_fffe, 0, 1'b0);
		// mixed signs
		queue_div(ACT_SQUO, 32'h0000_0007, 32'hffff_fffe, 0, 1'b0);
		queue_div(ACT_SREM, 32'h0000_0007, 32'hffff_fffe, 0, 1'b0);
		queue_div(ACT_SQUO, 32'hffff_fff9, 32'h0000_0002, 0, 1'b0);
		queue_div(ACT_SREM, 32'hffff_fff9, 32'h0000_0002, 0, 1'b0);
		queue_div(ACT_SQUO, 32'h7fff_ffff, 32'h8000_0000, 0, 1'b0);
		queue_div(ACT_SREM, 32'h7fff_ffff, 32'h8000_0000, 0, 1'b0);
		queue_div(ACT_SQUO, 32'h8000_0000, 32'h0000_0001, 0, 1'b0);
		// unsigned extremes
		queue_div(ACT_UQUO, 32'hffff_ffff, 32'h0000_0001, 0, 1'b0);
		queue_div(ACT_UREM, 32'hffff_ffff, 32'h0000_0001, 0, 1'b0);
		queue_div(ACT_UQUO, 32'hffff_ffff, 32'hffff_ffff, 0, 1'b0);
		queue_div(ACT_UREM, 32'hffff_fffe, 32'hffff_ffff, 0, 1'b0);
		queue_div(ACT_UQUO, 32'h0000_0000, 32'h0000_0005, 0, 1'b0);
		queue_div(ACT_UREM, 32'h0000_0003, 32'h8000_0000, 0, 1'b0);
		queue_div(ACT_UQUO, 32'h8000_0000, 32'h0000_0002, 0, 1'b0);

		// random part; the first one waits for the directed set to drain
		for (int i = 0; i < 400; i++) begin
			act = 2'($urandom_range(0, 3));
			a = pick_operand();
			b = pick_operand();
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				b = '0;
			end else if (roll < 9) begin
				a = 32'h8000_0000;
				b = 32'hffff_ffff;
			end
			queue_div(act, a, b, (i >= 120 && i < 200) || (i >= 300 && i < 360) ? 0 : pick_gap(),
				i == 0 || i == 250);
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_divs.size() != 0 || req_valid)
			@(posedge clk);
		while (due_answers.size() != 0)
			@(posedge clk);
		repeat (DATA_W + 20) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#800000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/idiv_pkg.sv
src/idiv_prep.sv
src/idiv_cell.sv
src/idiv_post.sv
src/integer_divider_signed_unsigned.sv
src/idiv_check.sv
test/tb_integer_divider_signed_unsigned.sv
